@@ rtl/core/flvha_pkg.sv @@
// Shared types and constants of the HEVC tag payload to Annex-B converter.
package flvha_pkg;

    typedef enum logic [3:0] {
        PH_HDR   = 4'd0,
        PH_CTS   = 4'd1,
        PH_LEN   = 4'd2,
        PH_DATA  = 4'd3,
        PH_SKIP  = 4'd4,
        PH_ATYPE = 4'd5,
        PH_CNT   = 4'd6,
        PH_NLEN  = 4'd7,
        PH_IDLE  = 4'd8
    } t_phase;

    localparam int IN_W  = 40;
    localparam int OUT_W = 80;

    localparam int OUT_START_BIT = 8;
    localparam int OUT_END_BIT   = 9;
    localparam int OUT_SEQ_BIT   = 10;
    localparam int OUT_PTS_LSB   = 11;
    localparam int OUT_DTS_LSB   = 45;
    localparam int OUT_TRUNC_BIT = 77;

    localparam int ENH_FLAG_BIT = 7;
    localparam logic [7:0] KIND_MASK    = 8'h0f;
    localparam logic [7:0] KIND_SEQ_HDR = 8'd0;
    localparam logic [7:0] KIND_FRAME   = 8'd1;
    localparam logic [7:0] KIND_FRAME_X = 8'd3;

    localparam logic [4:0] POS_MAX     = 5'd31;
    localparam logic [4:0] POS_HDR_END = 5'd4;
    localparam logic [4:0] POS_CTS_END = 5'd7;
    localparam logic [4:0] POS_RECORD  = 5'd27;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;
    localparam logic [1:0] SC_LAST = 2'd3;

    typedef struct packed {
        logic               is_start;
        logic [7:0]         data;
        logic               unit_end;
        logic               truncated;
        logic               from_seq;
        logic signed [33:0] pts;
        logic [31:0]        dts;
    } t_cmd;

endpackage

@@ rtl/core/flvha_front.sv @@
// Header and length parser that turns each payload byte into at most one command.
module flvha_front
    import flvha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_time,
    input  logic        i_last,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd
);

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic        r_enh, n_enh;
    logic [7:0]  r_kind, n_kind;
    logic [23:0] r_cts, n_cts;
    logic [7:0]  r_arrays, n_arrays;
    logic [15:0] r_units, n_units;
    logic [31:0] r_len, n_len;
    logic [1:0]  r_lseen, n_lseen;
    logic [31:0] r_left, n_left;
    logic [31:0] r_time, n_time;

    always_comb begin
        logic [15:0] units_dec;
        logic [15:0] cnt_val;
        logic [7:0]  arrays_dec;
        logic [31:0] left_dec;
        logic [31:0] start_len;
        logic        start;
        logic        done;
        logic        emit;

        n_phase  = r_phase;
        n_pos    = (r_pos != POS_MAX) ? r_pos + 5'd1 : r_pos;
        n_enh    = r_enh;
        n_kind   = r_kind;
        n_cts    = r_cts;
        n_arrays = r_arrays;
        n_units  = r_units;
        n_len    = r_len;
        n_lseen  = r_lseen;
        n_left   = r_left;
        n_time   = r_time;

        units_dec  = r_units - 16'd1;
        arrays_dec = r_arrays - 8'd1;
        left_dec   = r_left - 32'd1;
        cnt_val    = {r_units[7:0], i_byte};
        start_len  = '0;
        start      = 1'b0;
        done       = 1'b0;
        emit       = 1'b0;

        o_cmd.is_start  = 1'b0;
        o_cmd.data      = i_byte;
        o_cmd.unit_end  = 1'b0;
        o_cmd.truncated = 1'b0;
        o_cmd.from_seq  = (r_kind == KIND_SEQ_HDR);
        o_cmd.pts       = {2'b00, r_time} + {{10{r_cts[23]}}, r_cts};
        o_cmd.dts       = r_time;

        unique case (r_phase)
            PH_HDR: begin
                if (r_pos == '0) begin
                    n_time = i_time;
                    n_enh  = i_byte[ENH_FLAG_BIT];
                    if (i_byte[ENH_FLAG_BIT]) begin
                        n_kind = i_byte & KIND_MASK;
                    end
                end else if (r_pos == 5'd1 && !r_enh) begin
                    n_kind = i_byte;
                end
                if (r_pos >= POS_HDR_END) begin
                    priority if (r_kind == KIND_SEQ_HDR) begin
                        n_phase = PH_SKIP;
                    end else if (!r_enh || r_kind == KIND_FRAME_X) begin
                        n_phase = PH_LEN;
                    end else if (r_kind == KIND_FRAME) begin
                        n_phase = PH_CTS;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                    n_lseen = '0;
                end
            end
            PH_CTS: begin
                n_cts = {r_cts[15:0], i_byte};
                if (r_pos >= POS_CTS_END) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_len = {r_len[23:0], i_byte};
                if (r_lseen == 2'd3) begin
                    n_lseen   = '0;
                    start     = 1'b1;
                    start_len = {r_len[23:0], i_byte};
                end else begin
                    n_lseen = r_lseen + 2'd1;
                end
            end
            PH_DATA: begin
                n_left         = left_dec;
                emit           = 1'b1;
                o_cmd.unit_end = (left_dec == '0);
                done           = (left_dec == '0);
            end
            PH_SKIP: begin
                if (r_pos >= POS_RECORD) begin
                    n_arrays = i_byte;
                    n_phase  = (i_byte == '0) ? PH_IDLE : PH_ATYPE;
                end
            end
            PH_ATYPE: begin
                n_lseen = '0;
                n_phase = PH_CNT;
            end
            PH_CNT: begin
                n_units = cnt_val;
                if (r_lseen == 2'd1) begin
                    n_lseen = '0;
                    if (cnt_val == '0) begin
                        n_arrays = arrays_dec;
                        n_phase  = (arrays_dec == '0) ? PH_IDLE : PH_ATYPE;
                    end else begin
                        n_phase = PH_NLEN;
                    end
                end else begin
                    n_lseen = 2'd1;
                end
            end
            PH_NLEN: begin
                n_len = {16'd0, r_len[7:0], i_byte};
                if (r_lseen == 2'd1) begin
                    n_lseen   = '0;
                    start     = 1'b1;
                    start_len = {16'd0, r_len[7:0], i_byte};
                end else begin
                    n_lseen = 2'd1;
                end
            end
            default: begin
            end
        endcase

        if (start) begin
            n_left         = start_len;
            emit           = 1'b1;
            o_cmd.is_start = 1'b1;
            o_cmd.unit_end = (start_len == '0);
            if (start_len == '0) begin
                done = 1'b1;
            end else begin
                n_phase = PH_DATA;
            end
        end

        if (done) begin
            if (r_kind != KIND_SEQ_HDR) begin
                n_phase = PH_LEN;
            end else begin
                n_units = units_dec;
                if (units_dec == '0) begin
                    n_arrays = arrays_dec;
                    n_phase  = (arrays_dec == '0) ? PH_IDLE : PH_ATYPE;
                end else begin
                    n_phase = PH_NLEN;
                end
            end
        end

        if (i_last) begin
            if (emit && n_phase == PH_DATA) begin
                o_cmd.unit_end  = 1'b1;
                o_cmd.truncated = 1'b1;
            end
            n_phase  = PH_HDR;
            n_pos    = '0;
            n_enh    = 1'b0;
            n_kind   = '0;
            n_cts    = '0;
            n_arrays = '0;
            n_units  = '0;
            n_len    = '0;
            n_lseen  = '0;
            n_left   = '0;
        end

        o_cmd_valid = i_accept && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR;
            r_pos    <= '0;
            r_enh    <= 1'b0;
            r_kind   <= '0;
            r_cts    <= '0;
            r_arrays <= '0;
            r_units  <= '0;
            r_len    <= '0;
            r_lseen  <= '0;
            r_left   <= '0;
            r_time   <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_enh    <= n_enh;
            r_kind   <= n_kind;
            r_cts    <= n_cts;
            r_arrays <= n_arrays;
            r_units  <= n_units;
            r_len    <= n_len;
            r_lseen  <= n_lseen;
            r_left   <= n_left;
            r_time   <= n_time;
        end
    end

endmodule

@@ rtl/core/flvha_queue.sv @@
// Small register queue of commands between the parser and the output stage.
module flvha_queue
    import flvha_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/flvha_back.sv @@
// Output stage that expands start-code commands and holds the outgoing word.
module flvha_back
    import flvha_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    input  logic             i_tready,
    output logic             o_tvalid,
    output logic [OUT_W-1:0] o_tdata,
    output logic             o_tlast
);

    logic               r_valid;
    logic [1:0]         r_sub;
    logic [7:0]         r_byte;
    logic               r_start;
    logic               r_end;
    logic               r_seq;
    logic               r_trunc;
    logic signed [33:0] r_pts;
    logic [31:0]        r_dts;
    logic               r_last;
    logic               load;
    logic               final_word;

    assign load       = i_cmd_valid && (!r_valid || i_tready);
    assign final_word = !i_cmd.is_start || (r_sub == SC_LAST);
    assign o_pop      = load && final_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            if (i_cmd.is_start) begin
                r_sub <= r_sub + 2'd1;
            end
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pts  <= i_cmd.pts;
            r_dts  <= i_cmd.dts;
            r_seq  <= i_cmd.from_seq;
            r_last <= final_word;
            if (i_cmd.is_start) begin
                r_byte  <= (r_sub == SC_LAST) ? SC_ONE : SC_ZERO;
                r_start <= (r_sub == '0);
                r_end   <= (r_sub == SC_LAST) && i_cmd.unit_end;
                r_trunc <= (r_sub == SC_LAST) && i_cmd.truncated;
            end else begin
                r_byte  <= i_cmd.data;
                r_start <= 1'b0;
                r_end   <= i_cmd.unit_end;
                r_trunc <= i_cmd.truncated;
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tlast  = r_last;
    assign o_tdata  = {2'b00, r_trunc, r_dts, r_pts, r_seq, r_end, r_start, r_byte};

endmodule

@@ rtl/core/flv_hevc_payload_to_annexb.sv @@
// Top level of the HEVC video tag payload to Annex-B stream converter.
//
// The slave channel takes one payload byte per word with its message time;
// s_axis_tlast marks the final byte of a message. The master channel gives
// one Annex-B byte per word: each unit comes out as 00 00 00 01 followed by
// its bytes, with pts, dts and unit flags, and m_axis_tlast marks the last
// word caused by one input byte.
// The first word caused by a byte is written into the queue at the edge that
// accepts the byte and then registered in the output stage. The parser takes
// one byte per cycle while the queue is not full and hands at most one command
// per byte to a queue of QUEUE_DEPTH entries; the output stage sends one word
// per cycle while m_axis_tready is high, so a start code occupies it for four
// words. A start code adds three words per unit, and s_axis_tready falls
// whenever the queue is full; the length field of a configuration record unit
// has only two bytes, that of a coded-frame unit four.
// Synchronous reset returns the parser to the start of a message, empties
// the queue and drops the output word. When the receiver holds m_axis_tready
// low, the output word stays unchanged, the queue fills and then the slave
// side stalls; nothing is lost.
module flv_hevc_payload_to_annexb
    import flvha_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // data_byte[7:0], message_time[39:8]
    input  logic [IN_W-1:0]  s_axis_tdata,
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // out_byte[7:0], unit_start[8], unit_end[9], from_sequence_header[10],
    // present_time[44:11], decode_time[76:45], truncated[77], zero[79:78]
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    logic q_full;
    logic q_valid;
    t_cmd q_head;
    logic q_pop;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    flvha_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata[7:0]),
        .i_time      (s_axis_tdata[39:8]),
        .i_last      (s_axis_tlast),
        .o_cmd_valid (cmd_push),
        .o_cmd       (cmd_in)
    );

    flvha_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_head)
    );

    flvha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_head),
        .o_pop       (q_pop),
        .i_tready    (m_axis_tready),
        .o_tvalid    (m_axis_tvalid),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

endmodule

@@ rtl/core/flvha_checker.sv @@
// Port-level assertions for the converter and their binding to the top level.
module flvha_checker
    import flvha_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Output word changed while stalled.");

    a_start_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_START_BIT] |->
            m_axis_tdata[7:0] == SC_ZERO && !m_axis_tdata[OUT_END_BIT] && !m_axis_tlast)
        else $error("First start code word is malformed.");

    a_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_TRUNC_BIT] |->
            m_axis_tdata[OUT_END_BIT] && m_axis_tlast)
        else $error("Truncated word does not close its unit.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

endmodule

bind flv_hevc_payload_to_annexb flvha_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/annexb_stream_checker.sv @@
// Checker that predicts the Annex-B words of the payload converter and compares them.
`timescale 1ns / 100ps
module annexb_stream_checker
    import flvha_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [IN_W-1:0]  i_in_data,
    input  logic             i_in_last,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [OUT_W-1:0] i_out_data,
    input  logic             i_out_last,
    output int               o_mismatches,
    output int               o_words_due
);

    typedef struct packed {
        logic [7:0]         data;
        logic               unit_start;
        logic               unit_end;
        logic               from_seq;
        logic signed [33:0] pts;
        logic [31:0]        dts;
        logic               truncated;
        logic [1:0]         pad;
        logic               last_of_byte;
    } t_annexb_word;

    t_phase      phase;
    logic [4:0]  byte_pos;
    logic        enhanced;
    logic [7:0]  kind;
    logic [23:0] cts;
    logic [7:0]  arrays_left;
    logic [15:0] units_left;
    logic [31:0] len_acc;
    logic [1:0]  len_cnt;
    logic [31:0] unit_left;
    logic [31:0] time_latch;

    t_annexb_word words_due[$];
    t_annexb_word step_words[4];
    int           step_n;

    task automatic clear_parser();
        phase       = PH_HDR;
        byte_pos    = '0;
        enhanced    = 1'b0;
        kind        = '0;
        cts         = '0;
        arrays_left = '0;
        units_left  = '0;
        len_acc     = '0;
        len_cnt     = '0;
        unit_left   = '0;
    endtask

    task automatic emit(input logic [7:0] b, input logic st, input logic fin);
        t_annexb_word w;
        w.data         = b;
        w.unit_start   = st;
        w.unit_end     = fin;
        w.from_seq     = (kind == KIND_SEQ_HDR);
        w.pts          = {2'b00, time_latch} + {{10{cts[23]}}, cts};
        w.dts          = time_latch;
        w.truncated    = 1'b0;
        w.pad          = 2'b00;
        w.last_of_byte = 1'b0;
        step_words[step_n] = w;
        step_n++;
    endtask

    task automatic close_array();
        arrays_left = arrays_left - 8'd1;
        if (arrays_left == 0) begin
            phase = PH_IDLE;
        end else begin
            phase = PH_ATYPE;
        end
    endtask

    task automatic finish_unit();
        if (kind != KIND_SEQ_HDR) begin
            phase = PH_LEN;
        end else begin
            units_left = units_left - 16'd1;
            if (units_left == 0) begin
                close_array();
            end else begin
                phase = PH_NLEN;
            end
        end
    endtask

    task automatic open_unit(input logic [31:0] len);
        unit_left = len;
        emit(SC_ZERO, 1'b1, 1'b0);
        emit(SC_ZERO, 1'b0, 1'b0);
        emit(SC_ZERO, 1'b0, 1'b0);
        emit(SC_ONE, 1'b0, len == 0);
        if (len == 0) begin
            finish_unit();
        end else begin
            phase = PH_DATA;
        end
    endtask

    task automatic parse_payload_byte(input logic [7:0] b, input logic [31:0] msg_time,
                                      input logic eom);
        logic [4:0] pos;
        pos    = byte_pos;
        step_n = 0;
        if (byte_pos < POS_MAX) begin
            byte_pos = byte_pos + 5'd1;
        end
        case (phase)
            PH_HDR: begin
                if (pos == 0) begin
                    time_latch = msg_time;
                    enhanced   = b[ENH_FLAG_BIT];
                    if (enhanced) begin
                        kind = b & KIND_MASK;
                    end
                end else if (pos == 1 && !enhanced) begin
                    kind = b;
                end
                if (pos >= POS_HDR_END) begin
                    if (kind == KIND_SEQ_HDR) begin
                        phase = PH_SKIP;
                    end else if (!enhanced || kind == KIND_FRAME_X) begin
                        phase = PH_LEN;
                    end else if (kind == KIND_FRAME) begin
                        phase = PH_CTS;
                    end else begin
                        phase = PH_IDLE;
                    end
                    len_cnt = '0;
                end
            end
            PH_CTS: begin
                cts = {cts[15:0], b};
                if (pos >= POS_CTS_END) begin
                    phase = PH_LEN;
                end
            end
            PH_LEN: begin
                len_acc = {len_acc[23:0], b};
                if (len_cnt == 2'd3) begin
                    len_cnt = '0;
                    open_unit(len_acc);
                end else begin
                    len_cnt = len_cnt + 2'd1;
                end
            end
            PH_DATA: begin
                unit_left = unit_left - 32'd1;
                emit(b, 1'b0, unit_left == 0);
                if (unit_left == 0) begin
                    finish_unit();
                end
            end
            PH_SKIP: begin
                if (pos >= POS_RECORD) begin
                    arrays_left = b;
                    if (b == 0) begin
                        phase = PH_IDLE;
                    end else begin
                        phase = PH_ATYPE;
                    end
                end
            end
            PH_ATYPE: begin
                len_cnt = '0;
                phase   = PH_CNT;
            end
            PH_CNT: begin
                units_left = {units_left[7:0], b};
                if (len_cnt == 2'd1) begin
                    len_cnt = '0;
                    if (units_left == 0) begin
                        close_array();
                    end else begin
                        phase = PH_NLEN;
                    end
                end else begin
                    len_cnt = 2'd1;
                end
            end
            PH_NLEN: begin
                len_acc = {16'h0000, len_acc[7:0], b};
                if (len_cnt == 2'd1) begin
                    len_cnt = '0;
                    open_unit(len_acc);
                end else begin
                    len_cnt = 2'd1;
                end
            end
            default: begin
            end
        endcase
        if (eom) begin
            if (phase == PH_DATA && step_n > 0) begin
                step_words[step_n - 1].unit_end  = 1'b1;
                step_words[step_n - 1].truncated = 1'b1;
            end
            clear_parser();
        end
        if (step_n > 0) begin
            step_words[step_n - 1].last_of_byte = 1'b1;
        end
        for (int i = 0; i < step_n; i++) begin
            words_due.push_back(step_words[i]);
        end
    endtask

    task automatic report(input string what, input t_annexb_word want, input t_annexb_word got);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected byte %h start %b end %b seq %b pts %0d dts %h trunc %b last %b",
                     want.data, want.unit_start, want.unit_end, want.from_seq, want.pts,
                     want.dts, want.truncated, want.last_of_byte);
            $display("  actual   byte %h start %b end %b seq %b pts %0d dts %h trunc %b last %b pad %b",
                     got.data, got.unit_start, got.unit_end, got.from_seq, got.pts,
                     got.dts, got.truncated, got.last_of_byte, got.pad);
        end
    endtask

    always @(posedge i_clk) begin
        t_annexb_word got;
        t_annexb_word want;
        if (!i_rst_n) begin
            clear_parser();
            time_latch = '0;
            words_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                parse_payload_byte(i_in_data[7:0], i_in_data[39:8], i_in_last);
            end
            if (i_out_valid && i_out_ready) begin
                got.data         = i_out_data[7:0];
                got.unit_start   = i_out_data[OUT_START_BIT];
                got.unit_end     = i_out_data[OUT_END_BIT];
                got.from_seq     = i_out_data[OUT_SEQ_BIT];
                got.pts          = i_out_data[OUT_PTS_LSB +: 34];
                got.dts          = i_out_data[OUT_DTS_LSB +: 32];
                got.truncated    = i_out_data[OUT_TRUNC_BIT];
                got.pad          = i_out_data[OUT_W-1 -: 2];
                got.last_of_byte = i_out_last;
                if (words_due.size() == 0) begin
                    want = '0;
                    report("output word with none expected", want, got);
                end else begin
                    want = words_due.pop_front();
                    if (got !== want) begin
                        report("output word mismatch", want, got);
                    end
                end
            end
        end
        o_words_due = words_due.size();
    end

endmodule

@@ tb/tb_flv_hevc_payload_to_annexb.sv @@
// Testbench top for the HEVC payload to Annex-B converter: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps
module tb_flv_hevc_payload_to_annexb;
    import flvha_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_valid;
    logic             s_ready;
    logic [IN_W-1:0]  s_data;
    logic             s_last;
    logic             m_valid;
    logic             m_ready;
    logic [OUT_W-1:0] m_data;
    logic             m_last;
    int               mismatches;
    int               words_due;
    int               idle_pct;
    int               stall_pct;
    int               phase_bytes;
    logic [7:0]       msg_bytes[$];

    flv_hevc_payload_to_annexb u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last)
    );

    annexb_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_in_last    (s_last),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_out_last   (m_last),
        .o_mismatches (mismatches),
        .o_words_due  (words_due)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    task automatic send_message(input logic [31:0] msg_time, input bit may_cut,
                                input bit counts);
        int n;
        n = msg_bytes.size();
        if (may_cut && $urandom_range(4, 0) == 0) begin
            n = $urandom_range(n, 1);
        end
        for (int i = 0; i < n; i++) begin
            while ($urandom_range(99, 0) < idle_pct) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
            end
            s_valid <= 1'b1;
            s_data  <= {(i == 0) ? msg_time : $urandom(), msg_bytes[i]};
            s_last  <= (i == n - 1);
            do @(posedge i_clk); while (!s_ready);
        end
        if (counts) begin
            phase_bytes += n;
        end
    endtask

    task automatic put_len32(input logic [31:0] v);
        msg_bytes.push_back(v[31:24]);
        msg_bytes.push_back(v[23:16]);
        msg_bytes.push_back(v[15:8]);
        msg_bytes.push_back(v[7:0]);
    endtask

    task automatic build_frame(input bit enh, input logic [7:0] frame_kind);
        logic [31:0] len;
        msg_bytes.delete();
        if (enh) begin
            msg_bytes.push_back({1'b1, 3'($urandom), frame_kind[3:0]});
        end else begin
            msg_bytes.push_back({1'b0, 7'($urandom)});
            msg_bytes.push_back(frame_kind);
        end
        while (msg_bytes.size() < 5) begin
            msg_bytes.push_back(8'($urandom));
        end
        if (enh && frame_kind == KIND_FRAME) begin
            repeat (3) msg_bytes.push_back(8'($urandom));
        end
        repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(7, 0) == 0) begin
                len = $urandom();
                put_len32(len);
                repeat ($urandom_range(3, 0)) msg_bytes.push_back(8'($urandom));
                break;
            end
            len = $urandom_range(5, 0);
            put_len32(len);
            repeat (len) msg_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic build_seq_header(input bit enh);
        int arrays;
        int units;
        int len;
        msg_bytes.delete();
        if (enh) begin
            msg_bytes.push_back({1'b1, 3'($urandom), KIND_SEQ_HDR[3:0]});
        end else begin
            msg_bytes.push_back({1'b0, 7'($urandom)});
            msg_bytes.push_back(KIND_SEQ_HDR);
        end
        while (msg_bytes.size() < 27) begin
            msg_bytes.push_back(8'($urandom));
        end
        arrays = ($urandom_range(5, 0) == 0) ? 0 : $urandom_range(2, 1);
        msg_bytes.push_back(($urandom_range(9, 0) == 0) ? 8'($urandom) : 8'(arrays));
        repeat (arrays) begin
            units = $urandom_range(2, 0);
            msg_bytes.push_back(8'($urandom));
            msg_bytes.push_back(($urandom_range(7, 0) == 0) ? 8'($urandom) : 8'h00);
            msg_bytes.push_back(8'(units));
            repeat (units) begin
                len = $urandom_range(3, 0);
                msg_bytes.push_back(($urandom_range(7, 0) == 0) ? 8'($urandom) : 8'h00);
                msg_bytes.push_back(8'(len));
                repeat (len) msg_bytes.push_back(8'($urandom));
            end
        end
        repeat ($urandom_range(2, 0)) msg_bytes.push_back(8'($urandom));
    endtask

    task automatic build_ignored();
        logic [3:0] k;
        k = 4'($urandom_range(15, 3));
        if (k == KIND_FRAME_X[3:0]) begin
            k = 4'd2;
        end
        msg_bytes.delete();
        msg_bytes.push_back({1'b1, 3'($urandom), k});
        repeat ($urandom_range(8, 0)) msg_bytes.push_back(8'($urandom));
    endtask

    task automatic build_noise();
        msg_bytes.delete();
        repeat ($urandom_range(6, 1)) msg_bytes.push_back(8'($urandom));
    endtask

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int r;
        i_rst_n   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        s_last    <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Most negative composition offset, a zero-length unit, then a one-byte unit.
        msg_bytes = '{{1'b1, 3'b000, KIND_FRAME[3:0]}, 8'h68, 8'h76, 8'h63, 8'h31,
                      8'h80, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h01, 8'hff};
        send_message(32'hffff_ffff, 1'b0, 1'b1);
        // Legacy frame whose message ends right after a huge length.
        msg_bytes = '{8'h7f, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff};
        send_message(32'h0000_0000, 1'b0, 1'b1);
        // Unknown enhanced packet type.
        msg_bytes = '{{1'b1, 3'b111, 4'hf}, 8'haa};
        send_message($urandom(), 1'b0, 1'b0);
        // Message that ends inside the header.
        msg_bytes = '{8'h00, 8'h01};
        send_message($urandom(), 1'b0, 1'b1);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 70;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 70;
                end
                default: begin
                    idle_pct  = 7;
                    stall_pct = 7;
                end
            endcase
            phase_bytes = 0;
            if (p % 2 == 0) begin
                build_seq_header($urandom_range(1, 0));
                send_message($urandom(), 1'b0, 1'b0);
            end
            while (phase_bytes < 16) begin
                r = $urandom_range(99, 0);
                if (r < 22) begin
                    build_frame(1'b1, KIND_FRAME);
                end else if (r < 40) begin
                    build_frame(1'b1, KIND_FRAME_X);
                end else if (r < 60) begin
                    build_frame(1'b0, 8'($urandom_range(255, 1)));
                end else if (r < 78) begin
                    build_seq_header($urandom_range(1, 0));
                end else if (r < 88) begin
                    build_ignored();
                end else begin
                    build_noise();
                end
                send_message($urandom(), r < 78, r < 78 || r >= 88);
            end
        end
        s_valid <= 1'b0;
        s_last  <= 1'b0;
        @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && words_due == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
